/* hdl/nta_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest target aim angle: shared package
// Widths, register indexes, item types and the arctangent table used by the
// front end, the queue, the tracker and the CORDIC unit.
// ----------------------------------------------------------------------------
package nta_pkg;

   // Coordinate format, signed Q12.4.
   localparam int COORD_BITS      = 16;
   // Fraction bits of the output angle in degrees.
   localparam int ANGLE_FRAC_BITS = 7;
   // Number of CORDIC micro-rotations.
   localparam int CORDIC_STEPS    = 16;

   localparam int ANGLE_W       = 16;
   localparam int DIFF_W        = COORD_BITS + 1;
   localparam int SQ_W          = 2 * DIFF_W;
   localparam int DIST_W        = SQ_W + 1;
   localparam int PRESCALE_BITS = 24;
   localparam int CORDIC_W      = DIFF_W + PRESCALE_BITS + 3;
   localparam int ATAN_FRAC     = 16;
   localparam int ANGLE_ACC_W   = ATAN_FRAC + 11;
   localparam int ATAN_ENTRIES  = 24;
   localparam int ATAN_IDX_W    = $clog2(ATAN_ENTRIES);
   localparam int STEP_W        = $clog2(CORDIC_STEPS);

   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE   = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] target_x;
      logic signed [COORD_BITS-1:0] target_y;
      logic                         has_target;
      logic                         last;
   } nta_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } nta_qstat_type;

   // atan(2^-i) in degrees, scaled by 2^16.
   function automatic logic [ANGLE_ACC_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
      logic [ANGLE_ACC_W-1:0] val;
      case (idx)
         5'd0:    val = ANGLE_ACC_W'(2949120);
         5'd1:    val = ANGLE_ACC_W'(1740967);
         5'd2:    val = ANGLE_ACC_W'(919879);
         5'd3:    val = ANGLE_ACC_W'(466945);
         5'd4:    val = ANGLE_ACC_W'(234379);
         5'd5:    val = ANGLE_ACC_W'(117304);
         5'd6:    val = ANGLE_ACC_W'(58666);
         5'd7:    val = ANGLE_ACC_W'(29335);
         5'd8:    val = ANGLE_ACC_W'(14668);
         5'd9:    val = ANGLE_ACC_W'(7334);
         5'd10:   val = ANGLE_ACC_W'(3667);
         5'd11:   val = ANGLE_ACC_W'(1833);
         5'd12:   val = ANGLE_ACC_W'(917);
         5'd13:   val = ANGLE_ACC_W'(458);
         5'd14:   val = ANGLE_ACC_W'(229);
         5'd15:   val = ANGLE_ACC_W'(115);
         5'd16:   val = ANGLE_ACC_W'(57);
         5'd17:   val = ANGLE_ACC_W'(29);
         5'd18:   val = ANGLE_ACC_W'(14);
         5'd19:   val = ANGLE_ACC_W'(7);
         5'd20:   val = ANGLE_ACC_W'(4);
         5'd21:   val = ANGLE_ACC_W'(2);
         5'd22:   val = ANGLE_ACC_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* hdl/nta_front.sv */
// ----------------------------------------------------------------------------
// Nearest target aim angle: front end
// Accepts input items and keeps only those that matter to the tracker.
// ----------------------------------------------------------------------------
module nta_front import nta_pkg::*; (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_target_x,
   input  logic signed [COORD_BITS-1:0] req_target_y,
   input  logic                         req_has_target,
   input  logic                         req_last,
   input  logic                         active,
   input  nta_qstat_type                qstat,
   output logic                         push,
   output nta_item_type                 push_item
);

   logic accept;
   logic useful;

   // Items taken while disabled, and markers that do not close a frame, are dropped.
   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;
   assign useful    = active && (req_has_target || req_last);
   assign push      = accept && useful;

   assign push_item.target_x   = req_target_x;
   assign push_item.target_y   = req_target_y;
   assign push_item.has_target = req_has_target;
   assign push_item.last       = req_last;

endmodule

/* hdl/nta_queue.sv */
// ----------------------------------------------------------------------------
// Nearest target aim angle: item queue
// Short FIFO that decouples the front end from the tracker.
// ----------------------------------------------------------------------------
module nta_queue import nta_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  nta_item_type  push_item,
   input  logic          pop,
   output nta_item_type  head_item,
   output nta_qstat_type qstat
);

   nta_item_type        entry_ff [QUEUE_DEPTH];
   logic [QIDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QIDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QIDX_W:0]     count_ff,  count_in;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == (QIDX_W+1)'(QUEUE_DEPTH));
   assign head_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("queue read while empty");
`endif

endmodule

/* hdl/nta_cordic.sv */
// ----------------------------------------------------------------------------
// Nearest target aim angle: CORDIC vectoring unit
// Iterative atan2 in degrees, one micro-rotation per cycle, then rounding.
// ----------------------------------------------------------------------------
module nta_cordic import nta_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [DIFF_W-1:0]  dx,
   input  logic signed [DIFF_W-1:0]  dy,
   output logic                      done,
   output logic signed [ANGLE_W-1:0] angle
);

   localparam int SHIFT     = ATAN_FRAC - ANGLE_FRAC_BITS;
   localparam int LIMIT     = 180 << ANGLE_FRAC_BITS;
   localparam int ANG_MAX_I = (LIMIT < 32767) ? LIMIT : 32767;
   localparam int ANG_MIN_I = (-LIMIT > -32768) ? -LIMIT : -32768;
   localparam logic signed [ANGLE_ACC_W:0] RND_C   = (ANGLE_ACC_W+1)'(1 << (SHIFT - 1));
   localparam logic signed [ANGLE_ACC_W:0] ANG_MAX = (ANGLE_ACC_W+1)'(ANG_MAX_I);
   localparam logic signed [ANGLE_ACC_W:0] ANG_MIN = (ANGLE_ACC_W+1)'(ANG_MIN_I);
   localparam logic signed [ANGLE_ACC_W-1:0] Z_HALF_TURN = ANGLE_ACC_W'(180 << ATAN_FRAC);
   localparam int EXT_W = CORDIC_W - DIFF_W - PRESCALE_BITS;

   logic                          busy_ff,  busy_in;
   logic                          fin_ff,   fin_in;
   logic                          done_ff,  done_in;
   logic [STEP_W-1:0]             step_ff,  step_in;
   logic signed [CORDIC_W-1:0]    x_ff,     x_in;
   logic signed [CORDIC_W-1:0]    y_ff,     y_in;
   logic signed [ANGLE_ACC_W-1:0] z_ff,     z_in;
   logic signed [ANGLE_W-1:0]     angle_ff, angle_in;

   logic signed [CORDIC_W-1:0]    x_start, y_start, x_shift, y_shift;
   logic signed [ANGLE_ACC_W-1:0] atan_val;
   logic signed [ANGLE_ACC_W:0]   z_sum, z_round, z_clamp;

   assign x_start  = {{EXT_W{dx[DIFF_W-1]}}, dx, {PRESCALE_BITS{1'b0}}};
   assign y_start  = {{EXT_W{dy[DIFF_W-1]}}, dy, {PRESCALE_BITS{1'b0}}};
   assign x_shift  = x_ff >>> step_ff;
   assign y_shift  = y_ff >>> step_ff;
   assign atan_val = signed'(atan_lookup(ATAN_IDX_W'(step_ff)));

   always_comb begin
      z_sum   = {z_ff[ANGLE_ACC_W-1], z_ff} + RND_C;
      z_round = z_sum >>> SHIFT;
      if (z_round > ANG_MAX) begin
         z_clamp = ANG_MAX;
      end else if (z_round < ANG_MIN) begin
         z_clamp = ANG_MIN;
      end else begin
         z_clamp = z_round;
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      step_in  = step_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      angle_in = angle_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         if (dx[DIFF_W-1]) begin
            // Left half plane: mirror through the origin and start from +-180 degrees.
            x_in = -x_start;
            y_in = -y_start;
            z_in = dy[DIFF_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
         end else begin
            x_in = x_start;
            y_in = y_start;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_val;
         end else if (y_ff < 0) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_val;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         angle_in = ANGLE_W'(z_clamp);
         done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff && !fin_ff && !done_ff)
      else $error("CORDIC started while a run is in progress");
`endif

endmodule

/* hdl/nta_track.sv */
// ----------------------------------------------------------------------------
// Nearest target aim angle: tracker
// Squared distance compare per target, frame-end sequencing and result register.
// ----------------------------------------------------------------------------
module nta_track import nta_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] origin_x,
   input  logic signed [COORD_BITS-1:0] origin_y,
   input  nta_item_type                 head_item,
   input  nta_qstat_type                qstat,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic signed [ANGLE_W-1:0]    rsp_angle
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_CMP  = 6'b000100,
      ST_FEND = 6'b001000,
      ST_ROT  = 6'b010000,
      ST_OUT  = 6'b100000
   } nta_state_type;

   nta_state_type                 state_ff, state_in;
   logic signed [DIFF_W-1:0]      dx_ff, dx_in;
   logic signed [DIFF_W-1:0]      dy_ff, dy_in;
   logic signed [COORD_BITS-1:0]  cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0]  cur_y_ff, cur_y_in;
   logic                          has_ff, has_in;
   logic                          last_ff, last_in;
   logic [SQ_W-1:0]               sqx_ff, sqx_in;
   logic [SQ_W-1:0]               sqy_ff, sqy_in;
   logic [DIST_W-1:0]             best_dist_ff, best_dist_in;
   logic signed [COORD_BITS-1:0]  best_x_ff, best_x_in;
   logic signed [COORD_BITS-1:0]  best_y_ff, best_y_in;
   logic                          any_seen_ff, any_seen_in;
   logic signed [ANGLE_W-1:0]     held_angle_ff, held_angle_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic signed [ANGLE_W-1:0]     rsp_angle_ff, rsp_angle_in;

   logic signed [SQ_W-1:0]        prod_x, prod_y;
   logic [DIST_W-1:0]             sum_sq;
   logic signed [DIFF_W-1:0]      head_dx, head_dy, best_dx, best_dy;
   logic                          cordic_start, cordic_done, out_load;
   logic signed [ANGLE_W-1:0]     cordic_angle;

   assign prod_x  = dx_ff * dx_ff;
   assign prod_y  = dy_ff * dy_ff;
   assign sum_sq  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign head_dx = {head_item.target_x[COORD_BITS-1], head_item.target_x}
                  - {origin_x[COORD_BITS-1], origin_x};
   assign head_dy = {head_item.target_y[COORD_BITS-1], head_item.target_y}
                  - {origin_y[COORD_BITS-1], origin_y};
   assign best_dx = {best_x_ff[COORD_BITS-1], best_x_ff} - {origin_x[COORD_BITS-1], origin_x};
   assign best_dy = {best_y_ff[COORD_BITS-1], best_y_ff} - {origin_y[COORD_BITS-1], origin_y};

   nta_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .dx    (best_dx),
      .dy    (best_dy),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   always_comb begin
      state_in      = state_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      has_in        = has_ff;
      last_in       = last_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      best_dist_in  = best_dist_ff;
      best_x_in     = best_x_ff;
      best_y_in     = best_y_ff;
      any_seen_in   = any_seen_ff;
      held_angle_in = held_angle_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_angle_in  = rsp_angle_ff;
      pop           = 1'b0;
      cordic_start  = 1'b0;
      out_load      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            sqx_in   = unsigned'(prod_x);
            sqy_in   = unsigned'(prod_y);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // Strict compare keeps the first of equally distant targets.
            if (has_ff && (!any_seen_ff || sum_sq < best_dist_ff)) begin
               best_dist_in = sum_sq;
               best_x_in    = cur_x_ff;
               best_y_in    = cur_y_ff;
               any_seen_in  = 1'b1;
            end
            if (last_ff) begin
               state_in = ST_FEND;
            end else if (!qstat.empty) begin
               pop      = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FEND: begin
            if (any_seen_ff) begin
               cordic_start = 1'b1;
               state_in     = ST_ROT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_ROT: begin
            if (cordic_done) begin
               held_angle_in = cordic_angle;
               state_in      = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               rsp_found_in = any_seen_ff;
               rsp_angle_in = held_angle_ff;
               any_seen_in  = 1'b0;
               best_dist_in = '1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (pop) begin
         dx_in    = head_dx;
         dy_in    = head_dy;
         cur_x_in = head_item.target_x;
         cur_y_in = head_item.target_y;
         has_in   = head_item.has_target;
         last_in  = head_item.last;
      end

      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         any_seen_ff   <= 1'b0;
         best_dist_ff  <= '1;
         held_angle_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         any_seen_ff   <= any_seen_in;
         best_dist_ff  <= best_dist_in;
         held_angle_ff <= held_angle_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      has_ff       <= has_in;
      last_ff      <= last_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      best_x_ff    <= best_x_in;
      best_y_ff    <= best_y_in;
      rsp_found_ff <= rsp_found_in;
      rsp_angle_ff <= rsp_angle_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_angle = rsp_angle_ff;

`ifndef NO_ASSERTIONS
   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      out_load |=> !any_seen_ff && state_ff == ST_IDLE)
      else $error("frame state not cleared after result");
   a_cordic_only_found: assert property (@(posedge clock) disable iff (reset)
      cordic_start |-> any_seen_ff)
      else $error("angle computed for an empty frame");
`endif

endmodule

/* hdl/nearest_target_aim_angle.sv */
// The tracker subtracts, squares and compares each queued target in turn,
// and can take the next item from the queue during the compare; it runs one
// CORDIC angle computation at the end of each frame that has a target.
// Reset is synchronous, active high: origin 0, disabled, queue empty, held angle 0.
// ----------------------------------------------------------------------------
// Nearest target aim angle: top level
// Tracks the target nearest to a configured origin over a frame and reports
// the aim angle to it in degrees (signed, ANGLE_FRAC_BITS fraction bits).
// ----------------------------------------------------------------------------
//
// Structure: the front end accepts items and drops those that cannot change
// anything (any item while disabled, and markers that do not end a frame).
// The remaining items wait in a four-entry queue, so input is still accepted
// while the tracker is busy with a frame end, until the queue fills. The
// tracker computes the squared distance of each target to the origin, keeps
// the first nearest one, and at the end of a frame runs the iterative CORDIC
// unit to get atan2 of the offset. The result sits in an output register, so
// the tracker goes on with the next frame while a result waits to be taken.
//
// Configuration writes are always ready and take effect on the next cycle.
module nearest_target_aim_angle import nta_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   // Input item channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_target_x,
   input  logic signed [COORD_BITS-1:0] req_target_y,
   input  logic                         req_has_target,
   input  logic                         req_last,
   // Result item channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic signed [ANGLE_W-1:0]    rsp_angle,
   // Configuration write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [COORD_BITS-1:0]        csr_wdata
);

   logic signed [COORD_BITS-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_BITS-1:0] origin_y_ff, origin_y_in;
   logic                         active_ff,   active_in;

   nta_qstat_type qstat;
   nta_item_type  push_item, head_item;
   logic          push, pop;

   // Registers are written directly; the index beyond the list is ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      active_in   = active_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_in = signed'(csr_wdata);
            CSR_ORIGIN_Y: origin_y_in = signed'(csr_wdata);
            CSR_ACTIVE:   active_in   = csr_wdata[0];
            default:      active_in   = active_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         active_ff   <= 1'b0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         active_ff   <= active_in;
      end
   end

   nta_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_target_x   (req_target_x),
      .req_target_y   (req_target_y),
      .req_has_target (req_has_target),
      .req_last       (req_last),
      .active         (active_ff),
      .qstat          (qstat),
      .push           (push),
      .push_item      (push_item)
   );

   nta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .qstat     (qstat)
   );

   nta_track u_track (
      .clock     (clock),
      .reset     (reset),
      .origin_x  (origin_x_ff),
      .origin_y  (origin_y_ff),
      .head_item (head_item),
      .qstat     (qstat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_found (rsp_found),
      .rsp_angle (rsp_angle)
   );

endmodule
